// File: rtl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

    // One classified request from the front part to the back part.
    // add: the four neighbour weights of the centre cell count.
    // last: the final request of a grid; the energy follows it.
    typedef struct packed {
        logic       add;
        logic       last;
        logic [2:0] centre;
        logic [2:0] below;
        logic [2:0] above;
        logic [2:0] left;
        logic [2:0] right;
    } req_t;

    // cos(2*pi*d/Q) in signed Q1.14, row Q, column d
    localparam logic signed [15:0] COS_ROM [9][8] = '{
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, -16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd5063, -16'sd13255, -16'sd13255, 16'sd5063,
          16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd8192, -16'sd8192, -16'sd16384, -16'sd8192,
          16'sd8192, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd10215, -16'sd3646, -16'sd14761, -16'sd14761,
          -16'sd3646, 16'sd10215, 16'sd0},
        '{16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384,
          -16'sd11585, 16'sd0, 16'sd11585}
    };

    // Reduce a spin modulo q by repeated subtraction (at most three steps).
    function automatic logic [2:0] spin_mod(input logic [2:0] v, input int q);
        logic [3:0] t;
        t = {1'b0, v};
        for (int i = 0; i < 4; i++) begin
            if (t >= 4'(q)) begin
                t = t - 4'(q);
            end
        end
        return t[2:0];
    endfunction

    // Coupling weight of spins a and b: table entry at (a-b) mod q.
    function automatic logic signed [15:0] cos_weight(input logic [2:0] a,
                                                      input logic [2:0] b,
                                                      input int q);
        logic [2:0] am;
        logic [2:0] bm;
        logic [3:0] d;
        am = spin_mod(a, q);
        bm = spin_mod(b, q);
        if (am >= bm) begin
            d = {1'b0, am} - {1'b0, bm};
        end else begin
            d = {1'b0, am} + 4'(q) - {1'b0, bm};
        end
        return COS_ROM[q][d[2:0]];
    endfunction

endpackage

// File: rtl/ple_front.sv
`timescale 1ns / 1ps

module ple_front #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    spin,
    input  logic [6:0]    row_count,
    input  logic [6:0]    col_count,
    output logic          req_valid,
    input  logic          req_ready,
    output ple_pkg::req_t req
);

    localparam int CA = $clog2(MAX_COLS);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RA = $clog2(MAX_ROWS);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [CA-1:0] col_pos_reg;
    logic [CA-1:0] col_pos_next;
    logic [RA-1:0] row_pos_reg;
    logic [RA-1:0] row_pos_next;
    logic [CW-1:0] cols_eff;
    logic [RW-1:0] rows_eff;
    logic [CW:0]   c_plus1;
    logic [CW:0]   c_plus2;
    logic [RW-1:0] r_plus1;
    logic          col_end;
    logic          row_end;
    logic          interior;
    logic          accept;
    logic          advance;

    // lookup stage: one item with the line store entry of its column
    logic          s1_valid_reg;
    logic [2:0]    s1_spin_reg;
    logic [CA-1:0] s1_col_reg;
    logic          s1_last_reg;
    logic          s1_int_reg;
    logic [5:0]    rd_reg;          // {upper, middle} before this item's write

    // the previous item (centre candidate) and the one before it
    logic          h_int_reg;
    logic [2:0]    h_mid_reg;
    logic [2:0]    h_up_reg;
    logic [2:0]    h_spin_reg;
    logic [2:0]    h_mid2_reg;

    logic [5:0]    line_mem [MAX_COLS];

    always_comb
    begin
        int cols_i;
        int rows_i;
        cols_i = int'(col_count);
        rows_i = int'(row_count);
        if (cols_i < 3) cols_i = 3;
        if (cols_i > MAX_COLS) cols_i = MAX_COLS;
        if (rows_i < 3) rows_i = 3;
        if (rows_i > MAX_ROWS) rows_i = MAX_ROWS;
        cols_eff = CW'(cols_i);
        rows_eff = RW'(rows_i);
    end

    assign c_plus1  = (CW+1)'(col_pos_reg) + (CW+1)'(1);
    assign c_plus2  = (CW+1)'(col_pos_reg) + (CW+1)'(2);
    assign r_plus1  = RW'(row_pos_reg) + RW'(1);
    assign col_end  = c_plus1 >= (CW+1)'(cols_eff);
    assign row_end  = r_plus1 >= rows_eff;
    assign interior = (row_pos_reg >= RA'(2)) && (col_pos_reg != '0)
                      && (c_plus2 <= (CW+1)'(cols_eff));

    always_comb
    begin
        if (col_end) begin
            col_pos_next = '0;
            row_pos_next = row_end ? '0 : RA'(r_plus1);
        end else begin
            col_pos_next = CA'(c_plus1);
            row_pos_next = row_pos_reg;
        end
    end

    assign in_ready = !s1_valid_reg || req_ready;
    assign accept   = in_valid && in_ready;
    assign advance  = s1_valid_reg && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            h_int_reg    <= 1'b0;
        end else begin
            if (accept) begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                h_int_reg <= s1_int_reg;
            end
        end
    end

    // Line store: read at acceptance, write back {old middle, spin} while
    // the item sits in the lookup stage. The same column comes round again
    // only three or more items later.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            rd_reg      <= line_mem[col_pos_reg];
            s1_spin_reg <= spin;
            s1_col_reg  <= col_pos_reg;
            s1_last_reg <= col_end && row_end;
            s1_int_reg  <= interior;
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= {rd_reg[2:0], s1_spin_reg};
        end
        if (advance) begin
            h_mid_reg  <= rd_reg[2:0];
            h_up_reg   <= rd_reg[5:3];
            h_spin_reg <= s1_spin_reg;
            h_mid2_reg <= h_mid_reg;
        end
    end

    // The centre is the previous item's column; its right neighbour is the
    // middle entry read for this item.
    assign req_valid  = s1_valid_reg;
    assign req.add    = h_int_reg;
    assign req.last   = s1_last_reg;
    assign req.centre = h_mid_reg;
    assign req.below  = h_spin_reg;
    assign req.above  = h_up_reg;
    assign req.left   = h_mid2_reg;
    assign req.right  = rd_reg[2:0];

endmodule

// File: rtl/ple_queue.sv
`timescale 1ns / 1ps

module ple_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  ple_pkg::req_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output ple_pkg::req_t rd_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    ple_pkg::req_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          push;
    logic          pop;

    assign wr_ready = count_reg != (AW+1)'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/ple_back.sv
`timescale 1ns / 1ps

module ple_back #(
    parameter int NUM_STATES = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ple_pkg::req_t      req,
    input  logic signed [15:0] coupling,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] energy
);

    logic signed [17:0] sum_next;

    logic               b1_valid_reg;
    logic               b1_last_reg;
    logic signed [17:0] b1_sum_reg;
    logic signed [30:0] acc_reg;
    logic               t_valid_reg;
    logic signed [30:0] tot_reg;
    logic               m_valid_reg;
    logic signed [46:0] prod_reg;
    logic               e_valid_reg;
    logic signed [47:0] energy_reg;

    logic e_free;
    logic m_free;
    logic t_free;
    logic acc_adv;
    logic b1_free;
    logic pop;

    always_comb
    begin
        sum_next = 18'(ple_pkg::cos_weight(req.centre, req.below, NUM_STATES))
                 + 18'(ple_pkg::cos_weight(req.centre, req.above, NUM_STATES))
                 + 18'(ple_pkg::cos_weight(req.centre, req.left, NUM_STATES))
                 + 18'(ple_pkg::cos_weight(req.centre, req.right, NUM_STATES));
        if (!req.add) begin
            sum_next = '0;
        end
    end

    // only the final request of a grid moves past the accumulator
    assign e_free    = !e_valid_reg || out_ready;
    assign m_free    = !m_valid_reg || e_free;
    assign t_free    = !t_valid_reg || m_free;
    assign acc_adv   = b1_valid_reg && (!b1_last_reg || t_free);
    assign b1_free   = !b1_valid_reg || acc_adv;
    assign req_ready = b1_free;
    assign pop       = req_valid && b1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            b1_valid_reg <= 1'b0;
            acc_reg      <= '0;
            t_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            e_valid_reg  <= 1'b0;
        end else begin
            if (b1_free) begin
                b1_valid_reg <= req_valid;
            end
            if (acc_adv) begin
                acc_reg <= b1_last_reg ? '0 : acc_reg + 31'(b1_sum_reg);
            end
            if (t_free) begin
                t_valid_reg <= acc_adv && b1_last_reg;
            end
            if (m_free) begin
                m_valid_reg <= t_valid_reg;
            end
            if (e_free) begin
                e_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            b1_last_reg <= req.last;
            b1_sum_reg  <= sum_next;
        end
        if (t_free && acc_adv && b1_last_reg) begin
            tot_reg <= acc_reg + 31'(b1_sum_reg);
        end
        if (m_free && t_valid_reg) begin
            prod_reg <= tot_reg * coupling;
        end
        // halve toward minus infinity; the product always fits 48 bits
        if (e_free && m_valid_reg) begin
            energy_reg <= {{2{prod_reg[46]}}, prod_reg[46:1]};
        end
    end

    assign out_valid = e_valid_reg;
    assign energy    = energy_reg;

endmodule

// File: rtl/potts_lattice_energy.sv
// Potts lattice energy: one spin per ready cycle, one energy per padded grid.
// Energy path: lookup stage, queue, request, total, product, energy registers.
// Throughput: one spin per cycle unless the queue fills; the line store takes
// one read and one write each cycle, at different columns.
// Reset (rst_n low, asynchronous): counters, queue and valid flags clear and
// the registers return to 18 rows, 18 columns and J = 1.0; line store is not
// cleared, since no entry's value is used before it is written.
`timescale 1ns / 1ps

module potts_lattice_energy #(
    parameter int NUM_STATES = 2,
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         spin,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] energy
);

    // register indexes of the configuration port
    localparam logic [1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [1:0] REG_COL_COUNT = 2'd1;
    localparam logic [1:0] REG_COUPLING  = 2'd2;

    logic [6:0]         row_count_reg;
    logic [6:0]         col_count_reg;
    logic signed [15:0] coupling_reg;

    logic               req_valid;
    logic               req_ready;
    ple_pkg::req_t      req;
    logic               q_valid;
    logic               q_ready;
    ple_pkg::req_t      q_data;

    // Configuration is taken whenever the write enable is high; an index
    // outside the register list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_count_reg <= 7'd18;
            col_count_reg <= 7'd18;
            coupling_reg  <= 16'sd256;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data[6:0];
                REG_COL_COUNT: col_count_reg <= cfg_data[6:0];
                REG_COUPLING:  coupling_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: track the grid position, look up the two stored rows and
    // classify each spin into a request that names one centre cell.
    ple_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .spin      (spin),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    // Short queue: lets the front keep taking spins while the back waits
    // for the output to be taken.
    ple_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (req_valid),
        .wr_ready (req_ready),
        .wr_data  (req),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // Back: weight lookup, accumulation, scaling by J/2 and the output
    // register.
    ple_back #(
        .NUM_STATES (NUM_STATES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (q_valid),
        .req_ready (q_ready),
        .req       (q_data),
        .coupling  (coupling_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .energy    (energy)
    );

endmodule

// File: rtl/ple_checker.sv
`timescale 1ns / 1ps

module ple_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [47:0] energy
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(energy))
        else $error("result changed while stalled");

    // the halved product never reaches the top two bits
    a_energy_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> energy[47] == energy[46])
        else $error("energy outside the product range");

    // with no new request and the output drained, the pipeline empties
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!in_valid && out_ready, 1) && $past(!in_valid && out_ready, 2)
        && $past(!in_valid && out_ready, 3) |-> in_ready)
        else $error("input stalled with nothing pending");

endmodule

bind potts_lattice_energy ple_checker u_ple_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Build of the block under test; the predictor follows the same values.
    localparam int SPIN_STATES = 2;
    localparam int COL_LIMIT   = 64;
    localparam int ROW_LIMIT   = 64;

    // Register map of the configuration port.
    localparam logic [1:0] REG_ROWS     = 2'd0;
    localparam logic [1:0] REG_COLS     = 2'd1;
    localparam logic [1:0] REG_COUPLING = 2'd2;
    localparam logic [1:0] REG_SPARE    = 2'd3;

    // Idle time after the last energy is in; allow a good margin.
    localparam int SETTLE_CYCLES = 16;
    // Cycles without any handshake or register write before the run is abandoned.
    localparam int STALL_LIMIT   = 3000;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES   = 400;

    localparam longint ENERGY_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ENERGY_MIN = -ENERGY_MAX - 1;

    // cos(2*pi*d/Q) in signed Q1.14, row Q, column d.
    localparam int COS_Q14 [9][8] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{16384, -16384, 0, 0, 0, 0, 0, 0},
        '{16384, -8192, -8192, 0, 0, 0, 0, 0},
        '{16384, 0, -16384, 0, 0, 0, 0, 0},
        '{16384, 5063, -13255, -13255, 5063, 0, 0, 0},
        '{16384, 8192, -8192, -16384, -8192, 8192, 0, 0},
        '{16384, 10215, -3646, -14761, -14761, -3646, 10215, 0},
        '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585}
    };

    // How a queued grid is filled with spins.
    typedef enum int {FILL_RANDOM, FILL_UNIFORM, FILL_CHECKER} fill_style_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_wen   = 1'b0;
    logic [1:0]         cfg_index = REG_ROWS;
    logic [15:0]        cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [2:0]         spin      = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [47:0] energy;

    // Spin requests waiting to be offered, and energies still owed by the block.
    logic [2:0]         spin_backlog [$];
    logic signed [47:0] energy_due   [$];

    // Idling odds in percent, set per phase by the stimulus.
    int gap_pct   = 0;
    int stall_pct = 0;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int hold_asks = 0;

    bit spin_taken     = 1'b0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Shadow of the block: registers, line stores, running sum and position.
    logic [6:0]         rows_reg = 7'd18;
    logic [6:0]         cols_reg = 7'd18;
    logic signed [15:0] j_reg    = 16'sd256;
    logic [2:0]         above_line  [COL_LIMIT] = '{default: '0};
    logic [2:0]         centre_line [COL_LIMIT] = '{default: '0};
    longint             bond_sum = 0;
    int                 cur_row  = 0;
    int                 cur_col  = 0;

    // Grid shape as the stimulus sees it, to queue whole grids only.
    int grid_rows = 18;
    int grid_cols = 18;

    potts_lattice_energy #(
        .NUM_STATES (SPIN_STATES),
        .MAX_COLS   (COL_LIMIT),
        .MAX_ROWS   (ROW_LIMIT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .spin      (spin),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .energy    (energy)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Effective row or column count: below 3 acts as 3, above the limit as the limit.
    function automatic int grid_span(input logic [6:0] raw, input int limit);
        if (raw < 3)
        begin
            return 3;
        end
        if (raw > limit)
        begin
            return limit;
        end
        return int'(raw);
    endfunction

    // Coupling weight of two spins; the table index is the difference mod Q,
    // which also folds spins at or beyond Q.
    function automatic int bond_weight(input logic [2:0] a, input logic [2:0] b);
        int d;
        d = (int'(a) + 8 * SPIN_STATES - int'(b)) % SPIN_STATES;
        return COS_Q14[SPIN_STATES][d];
    endfunction

    // Advance the shadow by one accepted spin. The arriving spin completes the
    // lower neighbour of the centre one row up, so the centre's four bonds are
    // added now, provided the centre lies inside the halo.
    task automatic tally_spin(input logic [2:0] s);
        int     rows;
        int     cols;
        longint product;
        longint scaled;
        rows = grid_span(rows_reg, ROW_LIMIT);
        cols = grid_span(cols_reg, COL_LIMIT);
        if (cur_row >= 2 && cur_col >= 1 && cur_col + 2 <= cols && cur_col + 1 < COL_LIMIT)
        begin
            bond_sum += bond_weight(centre_line[cur_col], s);
            bond_sum += bond_weight(centre_line[cur_col], above_line[cur_col]);
            bond_sum += bond_weight(centre_line[cur_col], above_line[cur_col - 1]);
            bond_sum += bond_weight(centre_line[cur_col], centre_line[cur_col + 1]);
        end
        // Shift the column down the line stores.
        if (cur_col < COL_LIMIT)
        begin
            above_line[cur_col]  = centre_line[cur_col];
            centre_line[cur_col] = s;
        end
        if (cur_col + 1 >= cols)
        begin
            cur_col = 0;
            if (cur_row + 1 >= rows)
            begin
                // Last cell of the grid: halve sum*J rounding down, then saturate.
                product = bond_sum * longint'(j_reg);
                scaled  = product >>> 1;
                if (scaled > ENERGY_MAX)
                begin
                    scaled = ENERGY_MAX;
                end
                if (scaled < ENERGY_MIN)
                begin
                    scaled = ENERGY_MIN;
                end
                energy_due.push_back(scaled[47:0]);
                bond_sum = 0;
                cur_row  = 0;
            end
            else
            begin
                cur_row = cur_row + 1;
            end
        end
        else
        begin
            cur_col = cur_col + 1;
        end
    endtask

    // Sample every handshake at the rising edge: register writes and spin
    // requests advance the shadow, energies are checked against the oldest
    // one owed.
    always @(posedge clk)
    begin
        logic signed [47:0] want;
        spin_taken = rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_ROWS:     rows_reg = cfg_data[6:0];
                    REG_COLS:     cols_reg = cfg_data[6:0];
                    REG_COUPLING: j_reg    = cfg_data;
                    default:      ;
                endcase
            end
            if (spin_taken)
            begin
                tally_spin(spin);
            end
            if (out_valid && out_ready)
            begin
                if (energy_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("energy %0d given with none owed", energy);
                    end
                end
                else
                begin
                    want = energy_due.pop_front();
                    if (energy !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("energy mismatch: expected %0d, got %0d", want, energy);
                        end
                    end
                end
            end
        end
    end

    // Drive the spin channel on the falling edge. Hold an offered request
    // until it is taken; otherwise offer the next one or idle at random.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || spin_taken)
        begin
            if (spin_backlog.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                spin     <= spin_backlog.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Drive the energy channel's ready. A hold-off request drops ready for a
    // fixed stretch, counted here, so the block backs up and stalls its input.
    always @(negedge clk)
    begin
        int hold_left;
        int hold_seen;
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: abandon the run once nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wen || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("potts_lattice_energy regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // Wait until every request is taken and every energy is in, then let the
    // pipeline run dry.
    task automatic drain();
        while (spin_backlog.size() != 0 || in_valid || energy_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Reprogram the grid only once the block is idle.
    task automatic set_grid(input logic [15:0] rows_raw, input logic [15:0] cols_raw,
                            input logic [15:0] coupling_raw);
        drain();
        write_reg(REG_ROWS, rows_raw);
        write_reg(REG_COLS, cols_raw);
        write_reg(REG_COUPLING, coupling_raw);
        grid_rows = grid_span(rows_raw[6:0], ROW_LIMIT);
        grid_cols = grid_span(cols_raw[6:0], COL_LIMIT);
    endtask

    // Queue one whole grid of the current shape.
    task automatic queue_grid(input fill_style_t style, input logic [2:0] a,
                              input logic [2:0] b);
        for (int r = 0; r < grid_rows; r++)
        begin
            for (int c = 0; c < grid_cols; c++)
            begin
                case (style)
                    FILL_UNIFORM: spin_backlog.push_back(a);
                    FILL_CHECKER: spin_backlog.push_back(((r + c) % 2 == 1) ? a : b);
                    default:      spin_backlog.push_back(3'($urandom_range(7)));
                endcase
            end
        end
    endtask

    // Random grid with a random fill; counts are random in the upper bits too.
    task automatic random_grids(input int budget);
        int queued;
        int pick;
        logic [15:0] rows_raw;
        logic [15:0] cols_raw;
        logic [15:0] j_raw;
        rows_raw = {9'($urandom), 7'($urandom_range(3, 5))};
        cols_raw = {9'($urandom), 7'($urandom_range(3, 6))};
        if ($urandom_range(9) == 0)
        begin
            rows_raw[6:0] = 7'($urandom_range(2));
        end
        if ($urandom_range(9) == 0)
        begin
            cols_raw[6:0] = 7'($urandom_range(2));
        end
        pick = $urandom_range(9);
        j_raw = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : 16'($urandom);
        set_grid(rows_raw, cols_raw, j_raw);
        queued = 0;
        while (queued < budget)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
            begin
                queue_grid(FILL_UNIFORM, 3'($urandom), 3'd0);
            end
            else if (pick == 1)
            begin
                queue_grid(FILL_CHECKER, 3'($urandom), 3'($urandom));
            end
            else
            begin
                queue_grid(FILL_RANDOM, 3'd0, 3'd0);
            end
            queued += grid_rows * grid_cols;
        end
    endtask

    initial
    begin
        logic [2:0] mix [9] = '{3'd6, 3'd1, 3'd2, 3'd5, 3'd0, 3'd3, 3'd4, 3'd7, 3'd2};
        // Hold reset, then release it on a falling edge.
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Columns and J at their reset values (18 columns, J of one); only
        // the row count is shortened.
        write_reg(REG_ROWS, 16'd3);
        grid_rows = 3;
        queue_grid(FILL_CHECKER, 3'd7, 3'd0);

        // Counts below 3 act as 3; most negative J against fully opposed spins.
        set_grid(16'd0, 16'd2, 16'h8000);
        queue_grid(FILL_CHECKER, 3'd7, 3'd0);
        // Spins beyond Q-1 mixed in; most positive J; a write to the spare index.
        set_grid(16'd1, 16'd1, 16'h7FFF);
        write_reg(REG_SPARE, 16'hFFFF);
        foreach (mix[i])
        begin
            spin_backlog.push_back(mix[i]);
        end
        // Fully aligned grid with J of minus one LSB.
        set_grid(16'd2, 16'd0, 16'hFFFF);
        queue_grid(FILL_UNIFORM, 3'd5, 3'd0);

        // Random grids under each idling mix: none, sender, receiver, both.
        for (int mode = 0; mode < 4; mode++)
        begin
            drain();
            gap_pct   = (mode == 1) ? 55 : (mode == 3) ? 20 : 0;
            stall_pct = (mode == 2) ? 55 : (mode == 3) ? 20 : 0;
            for (int k = 0; k < 2; k++)
            begin
                random_grids(20);
            end
        end

        // Back the block up: tiny grids while the receiver holds off.
        drain();
        gap_pct   = 0;
        stall_pct = 0;
        set_grid(16'd3, 16'd3, 16'($urandom));
        hold_asks = hold_asks + 1;
        for (int k = 0; k < 8; k++)
        begin
            queue_grid(FILL_RANDOM, 3'd0, 3'd0);
        end

        // Counts above the limit clamp to the limit: rows, then columns.
        drain();
        gap_pct   = 20;
        stall_pct = 20;
        set_grid(16'h007F, 16'd3, 16'h7FFF);
        queue_grid(FILL_RANDOM, 3'd0, 3'd0);
        set_grid(16'd3, 16'd65, 16'h8000);
        queue_grid(FILL_RANDOM, 3'd0, 3'd0);

        drain();
        if (mismatch_count == 0)
        begin
            $display("potts_lattice_energy regression: pass");
        end
        else
        begin
            $display("potts_lattice_energy regression: fail");
        end
        $finish;
    end

endmodule
